// File: design/qsat_pkg.sv
// Shared types, constants and helpers for the quad separating-axis test.
// No dependencies; imported by every module in the design folder.
`timescale 1ns / 1ps
package qsat_pkg;

  localparam int CW    = 32;            // coordinate width, Q16.16
  localparam int NW    = 18;            // normal width, Q2.16
  localparam int OW    = CW + 2;        // overlap width
  localparam int PW    = CW + 4;        // projection width
  localparam int NCRN  = 4;
  localparam int NAXIS = 8;
  localparam int AXW   = 3;             // axis index width

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [NW-1:0] nrm_t;
  typedef logic signed [PW-1:0] proj_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  // one axis result from the lanes and merge stage
  typedef struct packed {
    logic  valid;
    logic  sep;
    proj_t ovl;
    nrm_t  nx;
    nrm_t  ny;
  } axis_res_t;

  // floor(c * n / 2^16), exact
  function automatic proj_t scaled_term(coord_t c, nrm_t n);
    logic signed [CW+NW-1:0] p;
    begin
      p = c * n;
      scaled_term = proj_t'(p >>> 16);
    end
  endfunction

endpackage

// File: design/qsat_normal.sv
// Edge normal unit: normalise an edge vector, integer square root and two
// divisions, one bit per cycle. Depends on qsat_pkg.
`timescale 1ns / 1ps
module qsat_normal import qsat_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic signed [CW:0] ex,
  input  logic signed [CW:0] ey,
  output logic         done,
  output logic         zero,
  output nrm_t         nx,
  output nrm_t         ny
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_NORM = 6'b000010,
    S_SQRT = 6'b000100,
    S_DIVS = 6'b001000,
    S_DIV  = 6'b010000,
    S_DONE = 6'b100000
  } st_t;

  st_t st_r, st_nxt;
  logic [CW:0]  ax_r, ay_r;
  logic         sx_r, sy_r, zero_r;
  logic [61:0]  v_r;
  logic [62:0]  root_r;
  logic [62:0]  bit_r;
  logic [5:0]   cnt_r;
  logic [47:0]  remx_r, remy_r;
  logic [17:0]  qx_r, qy_r;

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= S_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (start) st_nxt = S_NORM;
      S_NORM: begin
        if (zero_r) st_nxt = S_DONE;
        else if (ax_r[CW:30] == '0 && ay_r[CW:30] == '0 &&
                 (ax_r[29] | ay_r[29])) st_nxt = S_SQRT;
      end
      // the step with the lowest root bit is the last one
      S_SQRT: if (bit_r[0]) st_nxt = S_DIVS;
      S_DIVS: st_nxt = S_DIV;
      S_DIV:  if (cnt_r == '0) st_nxt = S_DONE;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // datapath: one shift, root step or quotient bit per cycle
  always_ff @(posedge clk) begin
    case (st_r)
      S_IDLE: if (start) begin
        ax_r   <= ex[CW] ? (CW+1)'(-ex) : ex;
        ay_r   <= ey[CW] ? (CW+1)'(-ey) : ey;
        sx_r   <= ex[CW];
        sy_r   <= ey[CW];
        zero_r <= (ex == '0) && (ey == '0);
      end
      S_NORM: begin
        if (ax_r[CW:30] != '0 || ay_r[CW:30] != '0) begin
          ax_r <= ax_r >> 1;
          ay_r <= ay_r >> 1;
        end else if (!(ax_r[29] | ay_r[29])) begin
          ax_r <= ax_r << 1;
          ay_r <= ay_r << 1;
        end else begin
          v_r    <= 62'(ax_r[29:0] * ax_r[29:0]) + 62'(ay_r[29:0] * ay_r[29:0]);
          root_r <= '0;
          bit_r  <= 63'(1) << 60;
        end
      end
      S_SQRT: begin
        if ({1'b0, v_r} >= root_r + bit_r) begin
          v_r    <= 62'({1'b0, v_r} - (root_r + bit_r));
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      S_DIVS: begin
        remx_r <= 48'({ax_r[29:0], 16'd0}) + 48'(root_r >> 1);
        remy_r <= 48'({ay_r[29:0], 16'd0}) + 48'(root_r >> 1);
        qx_r   <= '0;
        qy_r   <= '0;
        cnt_r  <= 6'd47;
      end
      S_DIV: begin
        // long division, dividend held in rem high to low
        if ((remx_r >> cnt_r) >= 48'(root_r)) begin
          remx_r <= remx_r - (48'(root_r) << cnt_r);
          qx_r   <= 18'({qx_r, 1'b1});
        end else qx_r <= 18'({qx_r, 1'b0});
        if ((remy_r >> cnt_r) >= 48'(root_r)) begin
          remy_r <= remy_r - (48'(root_r) << cnt_r);
          qy_r   <= 18'({qy_r, 1'b1});
        end else qy_r <= 18'({qy_r, 1'b0});
        cnt_r <= cnt_r - 6'd1;
      end
      default: ;
    endcase
  end

  assign done = (st_r == S_DONE);
  assign zero = zero_r;
  assign nx   = sy_r ? nrm_t'(-qy_r) : nrm_t'(qy_r);
  assign ny   = sx_r ? nrm_t'(qx_r) : nrm_t'(-qx_r);

`ifndef ASSERT_OFF
  a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done) else $error("done held");
  a_norm_range: assert property (@(posedge clk) disable iff (!rst_n)
    (done && !zero) |-> (qx_r <= 18'd65536 && qy_r <= 18'd65536))
    else $error("normal out of range");
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) |=> (st_r == S_IDLE)) else $error("no return to idle");
`endif

endmodule

// File: design/qsat_lane.sv
// Projection lane: project one corner of each quad on the current axis.
// Depends on qsat_pkg.
`timescale 1ns / 1ps
module qsat_lane import qsat_pkg::*; (
  input  point_t pa,
  input  point_t pb,
  input  nrm_t   nx,
  input  nrm_t   ny,
  output proj_t  da,
  output proj_t  db
);

  assign da = scaled_term(pa.x, nx) + scaled_term(pa.y, ny);
  assign db = scaled_term(pb.x, nx) + scaled_term(pb.y, ny);

endmodule

// File: design/qsat_merge.sv
// Merge stage: min/max across lanes, overlap test and running best axis.
// Depends on qsat_pkg.
`timescale 1ns / 1ps
module qsat_merge import qsat_pkg::*; (
  input  logic  clk,
  input  logic  clear,
  input  logic  en,
  input  proj_t da [NCRN],
  input  proj_t db [NCRN],
  input  nrm_t  nx,
  input  nrm_t  ny,
  output logic  sep_found,
  output axis_res_t best
);

  proj_t amin, amax, bmin, bmax;
  logic signed [PW:0] o1, o2, ov;
  axis_res_t best_r;

  // reduce the four lanes
  always_comb begin
    amin = da[0]; amax = da[0]; bmin = db[0]; bmax = db[0];
    for (int k = 1; k < NCRN; k++) begin
      if (da[k] < amin) amin = da[k];
      if (da[k] > amax) amax = da[k];
      if (db[k] < bmin) bmin = db[k];
      if (db[k] > bmax) bmax = db[k];
    end
    o1 = (PW+1)'(bmax) - (PW+1)'(amin);
    o2 = (PW+1)'(amax) - (PW+1)'(bmin);
    ov = (o1 < o2) ? o1 : o2;
  end

  assign sep_found = !(amax >= bmin && bmax >= amin);

  // keep the earliest smallest overlap
  always_ff @(posedge clk) begin
    if (clear) begin
      best_r.valid <= 1'b0;
      best_r.sep   <= 1'b0;
      best_r.ovl   <= '0;
      best_r.nx    <= '0;
      best_r.ny    <= '0;
    end else if (en) begin
      if (sep_found) best_r.sep <= 1'b1;
      else if (!best_r.valid || ov < (PW+1)'(best_r.ovl)) begin
        best_r.valid <= 1'b1;
        best_r.ovl   <= proj_t'(ov);
        best_r.nx    <= nx;
        best_r.ny    <= ny;
      end
    end
  end

  assign best = best_r;

endmodule

// File: design/quad_separating_axis_test.sv
// Top level of the quad separating-axis test: channel handshake, quad store,
// axis sequencer. Depends on qsat_pkg, qsat_normal, qsat_lane, qsat_merge.
`timescale 1ns / 1ps
// Usage:
//   Input channel in_*: one transaction per quad. in_tuser is the command
//   (0 stores the quad as quad A, 1 tests it against quad A). in_tdata holds
//   corner0_x, corner0_y, ... corner3_y, 32 bits each, lowest bits first.
//   Output channel out_*: one transaction per test, none per load.
//   A load is stored when it is accepted. A test runs the eight axes one
//   after another; an axis runs a start state, normalisation shifts, 31
//   root steps, a set-up state, 48 quotient steps, a done state and a
//   state for the four projection lanes and the merge. A zero-length edge
//   skips the root steps, the division and the projection. A test stops
//   at the first separating axis. One item is worked on at a time;
//   in_tready is low while a test runs or while a result waits in the
//   output register.
//   Reset: control state clears; the quad A store holds undefined data until
//   the first load. When the receiver stalls, the result holds in the
//   output register and no new item is taken.
module quad_separating_axis_test import qsat_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [255:0] in_tdata,  // corner0_x,corner0_y,...,corner3_x,corner3_y
  input  logic         in_tuser,  // command
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [71:0]  out_tdata, // normal_x[17:0], normal_y[35:18], min_overlap[69:36]
  output logic         out_tuser  // collides
);

  typedef enum logic [4:0] {
    T_IDLE  = 5'b00001,
    T_START = 5'b00010,
    T_WAIT  = 5'b00100,
    T_PROJ  = 5'b01000,
    T_OUT   = 5'b10000
  } tst_t;

  tst_t st_r, st_nxt;
  point_t qa_r [NCRN];
  point_t qb_r [NCRN];
  logic [AXW-1:0] axis_r;
  logic signed [CW:0] edge_x, edge_y;
  nrm_t nx_r, ny_r;
  logic n_done, n_zero;
  nrm_t n_nx, n_ny;
  proj_t da [NCRN];
  proj_t db [NCRN];
  logic sep;
  axis_res_t best;
  logic out_valid_r;
  logic [71:0] out_data_r;
  logic out_user_r;
  logic take;
  point_t p0, p1;
  logic [1:0] ki, kj;

  assign take      = in_tvalid && in_tready;
  assign in_tready = (st_r == T_IDLE) && !out_valid_r;

  // edge of the current axis
  assign ki = axis_r[1:0];
  assign kj = ki + 2'd1;
  assign p0 = axis_r[2] ? qb_r[ki] : qa_r[ki];
  assign p1 = axis_r[2] ? qb_r[kj] : qa_r[kj];
  assign edge_x = (CW+1)'(p1.x) - (CW+1)'(p0.x);
  assign edge_y = (CW+1)'(p1.y) - (CW+1)'(p0.y);

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= T_IDLE;
    else        st_r <= st_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      T_IDLE:  if (take && in_tuser == CMD_TEST) st_nxt = T_START;
      T_START: st_nxt = T_WAIT;
      T_WAIT: begin
        if (n_done) begin
          if (n_zero) st_nxt = (axis_r == AXW'(NAXIS-1)) ? T_OUT : T_START;
          else        st_nxt = T_PROJ;
        end
      end
      T_PROJ:  st_nxt = (sep || axis_r == AXW'(NAXIS-1)) ? T_OUT : T_START;
      T_OUT:   st_nxt = T_IDLE;
      default: st_nxt = T_IDLE;
    endcase
  end

  // store quads, advance axis
  always_ff @(posedge clk) begin
    if (take) begin
      for (int k = 0; k < NCRN; k++) begin
        if (in_tuser == CMD_LOAD) begin
          qa_r[k].x <= in_tdata[64*k +: 32];
          qa_r[k].y <= in_tdata[64*k+32 +: 32];
        end
        qb_r[k].x <= in_tdata[64*k +: 32];
        qb_r[k].y <= in_tdata[64*k+32 +: 32];
      end
      axis_r <= '0;
    end else if ((st_r == T_WAIT && n_done && n_zero) || st_r == T_PROJ) begin
      axis_r <= axis_r + AXW'(1);
    end
    if (n_done) begin
      nx_r <= n_nx;
      ny_r <= n_ny;
    end
  end

  qsat_normal u_normal (
    .clk(clk), .rst_n(rst_n), .start(st_r == T_START),
    .ex(edge_x), .ey(edge_y), .done(n_done), .zero(n_zero), .nx(n_nx), .ny(n_ny)
  );

  for (genvar g = 0; g < NCRN; g++) begin : g_lane
    qsat_lane u_lane (
      .pa(qa_r[g]), .pb(qb_r[g]), .nx(nx_r), .ny(ny_r), .da(da[g]), .db(db[g])
    );
  end

  qsat_merge u_merge (
    .clk(clk), .clear(take), .en(st_r == T_PROJ), .da(da), .db(db),
    .nx(nx_r), .ny(ny_r), .sep_found(sep), .best(best)
  );

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (st_r == T_OUT) begin
      out_valid_r <= 1'b1;
      out_user_r  <= !best.sep;
      if (best.sep) out_data_r <= '0;
      else if (!best.valid) out_data_r <= {2'b00, {OW{1'b1}}, 36'd0};
      else out_data_r <= {2'b00, OW'(best.ovl), best.ny, best.nx};
    end else if (out_valid_r && out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef ASSERT_OFF
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != T_IDLE) |-> !in_tready) else $error("ready while busy");
  a_out_from_test: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == T_OUT)) else $error("stray result");
  a_sep_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_user_r) |-> (out_data_r == '0)) else $error("sep data");
`endif

endmodule
